### rtl/hcp_pkg.sv
// Package for the hashed coordinate permutation block.
// Holds sizes, hash constants, register indexes, the controller state type
// and the command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hcp_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAP_BITS   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ROW_BITS   = 256;
   localparam int MAP_ROWS   = MAP_BITS / ROW_BITS;
   localparam int ROW_AW     = $clog2(MAP_ROWS);
   localparam int COL_AW     = $clog2(ROW_BITS);

   localparam logic [31:0] HASH_C0 = 32'h9E3779B9;
   localparam logic [31:0] HASH_C1 = 32'h85EBCA6B;
   localparam logic [31:0] HASH_C2 = 32'hC2B2AE35;
   localparam logic [31:0] HASH_C3 = 32'h27D4EB2F;
   localparam logic [31:0] HASH_C4 = 32'h165667B1;

   localparam logic [1:0] REG_SEED   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_H4,
      ST_H5,
      ST_DIV,
      ST_RD,
      ST_CHK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic h1;
      logic h2;
      logic h3;
      logic h4;
      logic h5;
      logic div_step;
      logic probe_chk;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic bit_free;
      logic exhausted;
      logic out_busy;
   } status_type;

   // A dimension of zero counts as one; above the maximum it saturates.
   function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [8:0] maxv);
      logic [8:0] r;
      if (v == 9'd0) r = 9'd1;
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/hcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### rtl/hcp_ctrl.sv
// Controller for the hashed coordinate permutation block.
// Sequences hash stages, the remainder divider and the bitmap probe. Uses hcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hcp_ctrl import hcp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_H1;
         ST_H1:   state_in = ST_H2;
         ST_H2:   state_in = ST_H3;
         ST_H3:   state_in = ST_H4;
         ST_H4:   state_in = ST_H5;
         ST_H5:   state_in = ST_DIV;
         ST_DIV:  if (status.div_last) state_in = ST_RD;
         ST_RD:   state_in = ST_CHK;
         ST_CHK: begin
            if (status.bit_free || status.exhausted) state_in = ST_FIN;
            else state_in = ST_RD;
         end
         ST_FIN:  if (!status.out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_H1:  cmd.h1 = 1'b1;
         ST_H2:  cmd.h2 = 1'b1;
         ST_H3:  cmd.h3 = 1'b1;
         ST_H4:  cmd.h4 = 1'b1;
         ST_H5:  cmd.h5 = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_RD: ;
         ST_CHK: cmd.probe_chk = 1'b1;
         ST_FIN: cmd.out_load = !status.out_busy;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

### rtl/hcp_dp.sv
// Datapath: configuration registers, hash stages, bit-serial remainder,
// occupancy bitmap with per-row valid bits, and the result register.
// Uses hcp_pkg and hcp_ram.
`timescale 1ns / 1ps
`default_nettype none
module hcp_dp import hcp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic [7:0]  req_pix_x,
   input  wire logic [7:0]  req_pix_y,
   input  wire logic        req_frame_start,
   input  wire logic        rsp_ready,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic             rsp_valid,
   output logic [15:0]      rsp_slot_index,
   output logic [15:0]      rsp_source_index,
   output logic             rsp_overflow
);

   localparam logic [8:0] MAXW = 9'(MAX_WIDTH);
   localparam logic [8:0] MAXH = 9'(MAX_HEIGHT);

   logic [31:0] seed_ff;
   logic [8:0]  fw_ff, fh_ff;
   logic [7:0]  x_ff, y_ff;
   logic [8:0]  w_ff, h_ff;
   logic [16:0] n_ff;
   logic [15:0] src_ff;
   logic [31:0] hash_ff, hash_in;
   logic [16:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] slot_ff;
   logic [16:0] tries_ff;
   logic        ovf_ff;
   logic [MAP_ROWS-1:0] row_vld_ff;
   logic        rsp_valid_ff;
   logic [15:0] out_slot_ff, out_src_ff;
   logic        out_ovf_ff;

   logic [17:0] div_r2;
   logic [16:0] rem_next;
   logic [ROW_BITS-1:0] ram_rdata, row_data;
   logic [ROW_AW-1:0]   row_sel;
   logic [COL_AW-1:0]   col_sel;
   logic        bit_busy;
   logic [16:0] slot_inc;

   assign row_sel = slot_ff[COL_AW +: ROW_AW];
   assign col_sel = slot_ff[COL_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd1;
         fw_ff   <= 9'd1;
         fh_ff   <= 9'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SEED:   seed_ff <= csr_data;
            REG_WIDTH:  fw_ff   <= csr_data[8:0];
            REG_HEIGHT: fh_ff   <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (1'b1)
         cmd.h1:  hash_in = (seed_ff ^ HASH_C0) ^ (32'(x_ff) * HASH_C1);
         cmd.h2:  hash_in = (hash_ff ^ (hash_ff >> 13)) * HASH_C2;
         cmd.h3:  hash_in = hash_ff ^ (32'(y_ff) * HASH_C3);
         cmd.h4:  hash_in = (hash_ff ^ (hash_ff >> 15)) * HASH_C4;
         cmd.h5:  hash_in = hash_ff ^ (hash_ff >> 16);
         default: hash_in = {hash_ff[30:0], 1'b0};
      endcase
   end

   // Restoring remainder, one dividend bit per cycle, MSB first.
   always_comb begin
      div_r2   = {rem_ff, hash_ff[31]};
      rem_next = (div_r2 >= {1'b0, n_ff}) ? 17'(div_r2 - {1'b0, n_ff}) : div_r2[16:0];
   end

   assign row_data  = row_vld_ff[row_sel] ? ram_rdata : '0;
   assign bit_busy  = row_data[col_sel];
   assign slot_inc  = {1'b0, slot_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_pix_x;
         y_ff <= req_pix_y;
         w_ff <= clamp_dim(fw_ff, MAXW);
         h_ff <= clamp_dim(fh_ff, MAXH);
      end
      if (cmd.h1) begin
         n_ff   <= 17'({8'd0, w_ff} * {8'd0, h_ff});
         src_ff <= 16'(({8'd0, y_ff} * {7'd0, w_ff}) + 16'(x_ff));
      end
      if (cmd.h1 || cmd.h2 || cmd.h3 || cmd.h4 || cmd.h5 || cmd.div_step) begin
         hash_ff <= hash_in;
      end
      if (cmd.h5) begin
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff + 5'd1;
         slot_ff  <= rem_next[15:0];
         tries_ff <= '0;
         ovf_ff   <= 1'b0;
      end
      if (cmd.probe_chk && bit_busy) begin
         if (17'(tries_ff + 17'd1) == n_ff) begin
            ovf_ff <= 1'b1;
         end else begin
            tries_ff <= tries_ff + 17'd1;
            slot_ff  <= (slot_inc == n_ff) ? 16'd0 : slot_inc[15:0];
         end
      end
      if (cmd.out_load) begin
         out_slot_ff <= ovf_ff ? 16'd0 : slot_ff;
         out_src_ff  <= src_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   // Row valid bits stand in for clearing the bitmap at frame start.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && req_frame_start) begin
            row_vld_ff <= '0;
         end else if (cmd.probe_chk && !bit_busy) begin
            row_vld_ff[row_sel] <= 1'b1;
         end
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   hcp_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(MAP_ROWS)
   ) u_map (
      .clock(clock),
      .we(cmd.probe_chk && !bit_busy),
      .waddr(row_sel),
      .wdata(row_data | (ROW_BITS'(1) << col_sel)),
      .raddr(row_sel),
      .rdata(ram_rdata)
   );

   assign status.div_last  = (cnt_ff == 5'd31);
   assign status.bit_free  = !bit_busy;
   assign status.exhausted = (17'(tries_ff + 17'd1) == n_ff);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = out_slot_ff;
   assign rsp_source_index = out_src_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule
`default_nettype wire

### rtl/hashed_coordinate_permutation.sv
// From the input transfer to rsp_valid the block runs 5 hash stages, 32 remainder
// steps, one RAM read and check per probed slot, and 1 result load.
// It takes one pixel at a time; the next is taken the cycle after the result is
// registered, while that result may still wait for rsp_ready.
// Reset clears the controller, the result valid and all bitmap row valid bits;
// seed resets to 1, frame_width and frame_height to 1. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module hashed_coordinate_permutation import hcp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_pix_x,
   input  wire logic [7:0]  req_pix_y,
   input  wire logic        req_frame_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_slot_index,
   output logic [15:0]      rsp_source_index,
   output logic             rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   hcp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   hcp_dp u_dp (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_pix_x(req_pix_x),
      .req_pix_y(req_pix_y),
      .req_frame_start(req_frame_start),
      .rsp_ready(rsp_ready),
      .cmd(cmd),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_slot_index(rsp_slot_index),
      .rsp_source_index(rsp_source_index),
      .rsp_overflow(rsp_overflow)
   );

endmodule
`default_nettype wire

### rtl/hcp_checker.sv
// Port-level checks for hashed_coordinate_permutation, attached by bind.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none
module hcp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_slot_index,
   input wire logic [15:0] rsp_source_index,
   input wire logic        rsp_overflow
);

   // An overflowed result never names a slot.
   a_ovf_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_slot_index == 16'd0)
      else $error("overflow result with nonzero slot");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
         && $stable(rsp_source_index) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // After a transfer in, the block is busy with that pixel.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // A result does not become valid straight after a transfer in taken while none was valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind hashed_coordinate_permutation hcp_checker u_hcp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_slot_index(rsp_slot_index),
   .rsp_source_index(rsp_source_index),
   .rsp_overflow(rsp_overflow)
);
`default_nettype wire

### verif/hashed_coordinate_permutation_tb.sv
// Self-checking testbench for the hashed coordinate permutation block.
// Depends on hcp_pkg and hashed_coordinate_permutation; a local placement model predicts
// each result but those typed in the table, and a directed table, then random frames, drive it.
`timescale 1ns / 1ps
`default_nettype none
module hashed_coordinate_permutation_tb;
   import hcp_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 540;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      logic [15:0] slot;
      logic [15:0] src;
      logic        ovf;
   } placement_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [1:0]    idx;
      logic [31:0]   data;
      logic [7:0]    x;
      logic [7:0]    y;
      logic          fs;
      logic          typed;
      placement_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_pix_x = '0;
   logic [7:0]  req_pix_y = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_slot_index;
   logic [15:0] rsp_source_index;
   logic        rsp_overflow;

   hashed_coordinate_permutation u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pix_x(req_pix_x), .req_pix_y(req_pix_y),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_slot_index(rsp_slot_index), .rsp_source_index(rsp_source_index),
      .rsp_overflow(rsp_overflow)
   );

   always #1 clock = ~clock;

   // Local copy of the block state.
   bit          occupancy [0:65535];
   logic [16:0] placed_count;
   logic [31:0] seed_reg;
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;

   placement_type expected_q[$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          overflows_seen = 0;
   int          frames_sent = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic logic [8:0] eff_dim(input logic [8:0] v);
      if (v == 9'd0) return 9'd1;
      if (v > 9'd256) return 9'd256;
      return v;
   endfunction

   function automatic logic [31:0] pixel_hash(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] h;
      h = seed_reg ^ HASH_C0;
      h = h ^ (x * HASH_C1);
      h = (h ^ (h >> 13)) * HASH_C2;
      h = h ^ (y * HASH_C3);
      h = (h ^ (h >> 15)) * HASH_C4;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // Linear probe with wrap through the occupancy map; updates the state.
   function automatic placement_type place_pixel(input logic [7:0] x, input logic [7:0] y,
                                                 input logic fs);
      placement_type p;
      logic [31:0] w;
      logic [31:0] n;
      logic [31:0] slot;
      logic [31:0] src;
      bit          found;
      w = {23'd0, eff_dim(width_reg)};
      n = w * {23'd0, eff_dim(height_reg)};
      found = 0;
      if (fs) begin
         foreach (occupancy[i]) occupancy[i] = 0;
         placed_count = '0;
      end
      slot = pixel_hash({24'd0, x}, {24'd0, y}) % n;
      for (int t = 0; t < n; t++) begin
         if (!occupancy[slot]) begin
            found = 1;
            break;
         end
         slot = (slot + 1 == n) ? 32'd0 : slot + 1;
      end
      src = {24'd0, y} * w + {24'd0, x};
      p.src = src[15:0];
      if (found) begin
         occupancy[slot] = 1;
         if (placed_count != 17'h1FFFF) placed_count = placed_count + 1;
         p.slot = slot[15:0];
         p.ovf  = 1'b0;
      end else begin
         p.slot = '0;
         p.ovf  = 1'b1;
      end
      return p;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SEED:   seed_reg   = data;
         REG_WIDTH:  width_reg  = data[8:0];
         REG_HEIGHT: height_reg = data[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Leaves valid high after the transfer; the next call may lower it for idle gaps, a drain lowers it.
   task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic fs,
                             input logic typed, input placement_type typed_res);
      placement_type p;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pix_x       <= x;
      req_pix_y       <= y;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = place_pixel(x, y, fs);
      expected_q.push_back(typed ? typed_res : p);
      items_sent++;
      if (fs) frames_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      placement_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_overflow) overflows_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: slot %0d src %0d ovf %0d",
                        rsp_slot_index, rsp_source_index, rsp_overflow);
         end else begin
            e = expected_q.pop_front();
            if (e.slot !== rsp_slot_index || e.src !== rsp_source_index ||
                e.ovf !== rsp_overflow) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected slot %0d src %0d ovf %0d, got %0d %0d %0d",
                           e.slot, e.src, e.ovf,
                           rsp_slot_index, rsp_source_index, rsp_overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout with %0d results outstanding", expected_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   dir_row_type dir_rows [] = '{
      // Reset geometry is one slot: the second pixel finds the frame full.
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0,   8'd0,   1'b1, 1'b1, '{16'd0, 16'd0,   1'b0}},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0,   8'd0,   1'b0, 1'b1, '{16'd0, 16'd0,   1'b1}},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd255, 8'd255, 1'b0, 1'b1, '{16'd0, 16'd510, 1'b1}},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd255, 8'd255, 1'b1, 1'b1, '{16'd0, 16'd510, 1'b0}},
      '{ROW_CFG,  REG_SEED,   32'd0,         8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_WIDTH,  32'd0,         8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_HEIGHT, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_UNUSED, 32'hA5A5_5A5A, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0,   8'd255, 1'b1, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd255, 8'd0,   1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_SEED,   32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_WIDTH,  32'd256,       8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_HEIGHT, 32'd256,       8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd255, 8'd255, 1'b1, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0,   8'd0,   1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd128, 8'd77,  1'b0, 1'b0, '0},
      // A three by two frame placed in raster order, then one pixel too many.
      '{ROW_CFG,  REG_SEED,   32'h0000_5A5A, 8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_WIDTH,  32'd3,         8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_CFG,  REG_HEIGHT, 32'd2,         8'd0, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0, 8'd0, 1'b1, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd1, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd2, 8'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd0, 8'd1, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd1, 8'd1, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd2, 8'd1, 1'b0, 1'b0, '0},
      '{ROW_ITEM, 2'd0, 32'd0, 8'd2, 8'd1, 1'b0, 1'b1, '{16'd0, 16'd5, 1'b1}}
   };

   initial begin
      int          sent_in_phase;
      int          pix;
      int          frame_len;
      int          w;
      int          n;
      logic [8:0]  raw_w;
      logic [8:0]  raw_h;
      int          pick;
      foreach (occupancy[i]) occupancy[i] = 0;
      placed_count = '0;
      seed_reg     = 32'd1;
      width_reg    = 9'd1;
      height_reg   = 9'd1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CFG) begin
            drain();
            write_reg(dir_rows[r].idx, dir_rows[r].data);
         end else begin
            send_pixel(dir_rows[r].x, dir_rows[r].y, dir_rows[r].fs,
                       dir_rows[r].typed, dir_rows[r].res);
         end
      end
      drain();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 14 : (mode == 1) ? 71 : 0;
         recv_idle = (mode == 0) ? 71 : (mode == 1) ? 14 : 0;
         for (int sub = 0; sub < 3; sub++) begin
            pick = $urandom_range(7);
            if (pick == 0) begin
               raw_w = 9'd256;
               raw_h = 9'd256;
            end else if (pick == 1) begin
               raw_w = ($urandom_range(1)) ? 9'd256 : 9'($urandom_range(511, 257));
               raw_h = 9'($urandom_range(2));
            end else begin
               raw_w = 9'($urandom_range(12, 1));
               raw_h = 9'($urandom_range(12, 1));
            end
            write_reg(REG_SEED, $urandom);
            write_reg(REG_WIDTH, {23'($urandom_range(8388607)), raw_w});
            write_reg(REG_HEIGHT, {23'($urandom_range(8388607)), raw_h});
            w = eff_dim(raw_w);
            n = w * eff_dim(raw_h);
            sent_in_phase = 0;
            while (sent_in_phase < RANDOM_ITEMS / 9) begin
               if ($urandom_range(99) < 15) begin
                  // Stray pixel at any coordinate, whether inside the current frame or not.
                  send_pixel(8'($urandom), 8'($urandom), $urandom_range(7) == 0, 1'b0, '0);
                  sent_in_phase++;
                  if (mode == 0 && sub == 0 && sent_in_phase == 10)
                     hold_requests++;
               end else begin
                  frame_len = (n > 40) ? $urandom_range(20, 4) : n + $urandom_range(3);
                  if (frame_len > RANDOM_ITEMS / 9 - sent_in_phase)
                     frame_len = RANDOM_ITEMS / 9 - sent_in_phase;
                  for (pix = 0; pix < frame_len; pix++) begin
                     send_pixel(8'(pix % w), 8'(pix / w), pix == 0, 1'b0, '0);
                     sent_in_phase++;
                     if (mode == 0 && sub == 0 && sent_in_phase == 10)
                        hold_requests++;
                  end
               end
            end
            drain();
         end
      end

      $display("Placed %0d pixels in %0d frames; %0d results checked, %0d overflows.",
               items_sent, frames_sent, results_seen, overflows_seen);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
